FILE: hdl/ecff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ecff_pkg;

    localparam int STATE_FRAC_BITS  = 12;
    localparam int OUT_FRAC_BITS    = 24;
    localparam int NORMAL_FRAC_BITS = 14;

    localparam int STATE_W  = 32;
    localparam int NORMAL_W = 16;
    localparam int AREA_W   = 31;
    localparam int FLUX_W   = 64;
    localparam int PROD_W   = 2 * FLUX_W;
    localparam int VN_PROD_W = STATE_W + NORMAL_W;
    localparam int VN_ACC_W  = VN_PROD_W + 2;
    localparam int VN_W      = VN_ACC_W - NORMAL_FRAC_BITS;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int COUNT_W    = $clog2(FIFO_DEPTH + 1);

    localparam int SHIFT_W     = 7;
    localparam int UCODE_STEPS = 18;
    localparam int STEP_W      = $clog2(UCODE_STEPS);
    localparam int REG_W       = 5;

    // operand and destination registers of the back end
    localparam logic [REG_W-1:0] REG_RHO   = 5'd0;
    localparam logic [REG_W-1:0] REG_U     = 5'd1;
    localparam logic [REG_W-1:0] REG_V     = 5'd2;
    localparam logic [REG_W-1:0] REG_W_VEL = 5'd3;
    localparam logic [REG_W-1:0] REG_P     = 5'd4;
    localparam logic [REG_W-1:0] REG_NX    = 5'd5;
    localparam logic [REG_W-1:0] REG_NY    = 5'd6;
    localparam logic [REG_W-1:0] REG_NZ    = 5'd7;
    localparam logic [REG_W-1:0] REG_AREA  = 5'd8;
    localparam logic [REG_W-1:0] REG_VN    = 5'd9;
    localparam logic [REG_W-1:0] REG_SEVEN = 5'd10;
    localparam logic [REG_W-1:0] REG_RV    = 5'd11;
    localparam logic [REG_W-1:0] REG_T     = 5'd12;
    localparam logic [REG_W-1:0] REG_KE    = 5'd13;
    localparam logic [REG_W-1:0] REG_E     = 5'd14;
    localparam logic [REG_W-1:0] REG_MASS  = 5'd15;
    localparam logic [REG_W-1:0] REG_MX    = 5'd16;
    localparam logic [REG_W-1:0] REG_MY    = 5'd17;
    localparam logic [REG_W-1:0] REG_MZ    = 5'd18;
    localparam logic [REG_W-1:0] REG_EN    = 5'd19;

    // product scaling codes
    localparam logic [2:0] SH_PROD  = 3'd0;
    localparam logic [2:0] SH_STATE = 3'd1;
    localparam logic [2:0] SH_NORM  = 3'd2;
    localparam logic [2:0] SH_SEVEN = 3'd3;
    localparam logic [2:0] SH_HALF  = 3'd4;

    typedef struct packed {
        logic signed [STATE_W-1:0]  density;
        logic signed [STATE_W-1:0]  velocity_x;
        logic signed [STATE_W-1:0]  velocity_y;
        logic signed [STATE_W-1:0]  velocity_z;
        logic signed [STATE_W-1:0]  pressure;
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [NORMAL_W-1:0] normal_y;
        logic signed [NORMAL_W-1:0] normal_z;
        logic [AREA_W-1:0]          face_area;
        logic                       last;
    } face_t;

    typedef struct packed {
        logic signed [FLUX_W-1:0] mass;
        logic signed [FLUX_W-1:0] mom_x;
        logic signed [FLUX_W-1:0] mom_y;
        logic signed [FLUX_W-1:0] mom_z;
        logic signed [FLUX_W-1:0] energy;
        logic                     last;
        logic                     overflow;
    } flux_t;

    typedef struct packed {
        logic [REG_W-1:0] src_a;
        logic [REG_W-1:0] src_b;
        logic [2:0]       shift;
        logic [REG_W-1:0] dst;
        logic             accum;
    } ucode_t;

    function automatic logic signed [STATE_W-1:0] avg_floor(
        input logic signed [STATE_W-1:0] a,
        input logic signed [STATE_W-1:0] b
    );
        logic signed [STATE_W:0] s;
        s = {a[STATE_W-1], a} + {b[STATE_W-1], b};
        return s[STATE_W:1];
    endfunction

    function automatic logic signed [SHIFT_W-1:0] shift_amount(input logic [2:0] code);
        logic signed [SHIFT_W-1:0] r;
        case (code)
            SH_PROD:  r = SHIFT_W'(2 * STATE_FRAC_BITS - OUT_FRAC_BITS);
            SH_STATE: r = SHIFT_W'(STATE_FRAC_BITS);
            SH_NORM:  r = SHIFT_W'(STATE_FRAC_BITS + NORMAL_FRAC_BITS - OUT_FRAC_BITS);
            SH_SEVEN: r = SHIFT_W'(STATE_FRAC_BITS + 1 - OUT_FRAC_BITS);
            SH_HALF:  r = SHIFT_W'(STATE_FRAC_BITS + 1);
            default:  r = '0;
        endcase
        return r;
    endfunction

    function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
        ucode_t u;
        case (step)
            5'd0:    u = '{REG_RHO, REG_VN,    SH_PROD,  REG_RV,   1'b0};
            5'd1:    u = '{REG_RV,  REG_AREA,  SH_STATE, REG_MASS, 1'b0};
            5'd2:    u = '{REG_RV,  REG_U,     SH_STATE, REG_T,    1'b0};
            5'd3:    u = '{REG_P,   REG_NX,    SH_NORM,  REG_T,    1'b1};
            5'd4:    u = '{REG_T,   REG_AREA,  SH_STATE, REG_MX,   1'b0};
            5'd5:    u = '{REG_RV,  REG_V,     SH_STATE, REG_T,    1'b0};
            5'd6:    u = '{REG_P,   REG_NY,    SH_NORM,  REG_T,    1'b1};
            5'd7:    u = '{REG_T,   REG_AREA,  SH_STATE, REG_MY,   1'b0};
            5'd8:    u = '{REG_RV,  REG_W_VEL, SH_STATE, REG_T,    1'b0};
            5'd9:    u = '{REG_P,   REG_NZ,    SH_NORM,  REG_T,    1'b1};
            5'd10:   u = '{REG_T,   REG_AREA,  SH_STATE, REG_MZ,   1'b0};
            5'd11:   u = '{REG_U,   REG_U,     SH_PROD,  REG_KE,   1'b0};
            5'd12:   u = '{REG_V,   REG_V,     SH_PROD,  REG_KE,   1'b1};
            5'd13:   u = '{REG_W_VEL, REG_W_VEL, SH_PROD, REG_KE,  1'b1};
            5'd14:   u = '{REG_P,   REG_SEVEN, SH_SEVEN, REG_E,    1'b0};
            5'd15:   u = '{REG_RHO, REG_KE,    SH_HALF,  REG_E,    1'b1};
            5'd16:   u = '{REG_E,   REG_VN,    SH_STATE, REG_T,    1'b0};
            5'd17:   u = '{REG_T,   REG_AREA,  SH_STATE, REG_EN,   1'b0};
            default: u = '{REG_RHO, REG_VN,    SH_PROD,  REG_RV,   1'b0};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ecff_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ecff_fifo import ecff_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire face_t push_face,
    output logic       full,
    input  wire logic  pop,
    output logic       pop_valid,
    output face_t      pop_face
);

    face_t                mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == COUNT_W'(FIFO_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_face  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_face;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ecff_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ecff_front import ecff_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_op,
    input  wire logic signed [STATE_W-1:0]  s_density,
    input  wire logic signed [STATE_W-1:0]  s_velocity_x,
    input  wire logic signed [STATE_W-1:0]  s_velocity_y,
    input  wire logic signed [STATE_W-1:0]  s_velocity_z,
    input  wire logic signed [STATE_W-1:0]  s_pressure,
    input  wire logic signed [NORMAL_W-1:0] s_normal_x,
    input  wire logic signed [NORMAL_W-1:0] s_normal_y,
    input  wire logic signed [NORMAL_W-1:0] s_normal_z,
    input  wire logic [AREA_W-1:0]          s_face_area,
    input  wire logic                       s_final_face,
    input  wire logic                       fifo_full,
    output logic                            push,
    output face_t                           push_face
);

    logic signed [STATE_W-1:0] held_density_reg;
    logic signed [STATE_W-1:0] held_velocity_x_reg;
    logic signed [STATE_W-1:0] held_velocity_y_reg;
    logic signed [STATE_W-1:0] held_velocity_z_reg;
    logic signed [STATE_W-1:0] held_pressure_reg;
    logic                      accept;

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && s_op;

    always_comb begin
        push_face.density    = avg_floor(held_density_reg, s_density);
        push_face.velocity_x = avg_floor(held_velocity_x_reg, s_velocity_x);
        push_face.velocity_y = avg_floor(held_velocity_y_reg, s_velocity_y);
        push_face.velocity_z = avg_floor(held_velocity_z_reg, s_velocity_z);
        push_face.pressure   = avg_floor(held_pressure_reg, s_pressure);
        push_face.normal_x   = s_normal_x;
        push_face.normal_y   = s_normal_y;
        push_face.normal_z   = s_normal_z;
        push_face.face_area  = s_face_area;
        push_face.last       = s_final_face;
    end

    // left beat loads the held cell state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_density_reg    <= '0;
            held_velocity_x_reg <= '0;
            held_velocity_y_reg <= '0;
            held_velocity_z_reg <= '0;
            held_pressure_reg   <= '0;
        end else if (accept && !s_op) begin
            held_density_reg    <= s_density;
            held_velocity_x_reg <= s_velocity_x;
            held_velocity_y_reg <= s_velocity_y;
            held_velocity_z_reg <= s_velocity_z;
            held_pressure_reg   <= s_pressure;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ecff_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module ecff_mul import ecff_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic signed [FLUX_W-1:0]  a,
    input  wire logic signed [FLUX_W-1:0]  b,
    input  wire logic signed [SHIFT_W-1:0] shift,
    output logic                           busy,
    output logic                           done,
    output logic signed [FLUX_W-1:0]       result,
    output logic                           sat
);

    localparam logic [1:0] M_IDLE  = 2'd0;
    localparam logic [1:0] M_PP    = 2'd1;
    localparam logic [1:0] M_SHIFT = 2'd2;
    localparam logic [1:0] M_SAT   = 2'd3;
    localparam int HALF_W = FLUX_W / 2;

    logic [1:0]                 state_reg, state_next;
    logic [1:0]                 cnt_reg;
    logic                       neg_reg;
    logic [FLUX_W-1:0]          ua_reg, ub_reg;
    logic [PROD_W-1:0]          acc_reg, mag_reg;
    logic signed [SHIFT_W-1:0]  sh_reg;
    logic                       inc_reg, lost_reg;
    logic signed [FLUX_W-1:0]   result_reg;
    logic                       sat_reg, done_reg;

    logic [HALF_W-1:0]          a_half, b_half;
    logic [FLUX_W-1:0]          pp;
    logic [PROD_W-1:0]          pp_pos;
    logic [SHIFT_W-2:0]         rsh, lsh;
    logic [SHIFT_W:0]           lost_pos;
    logic                       rem;
    logic [PROD_W-1:0]          mag2;
    logic [FLUX_W-1:0]          lim;
    logic                       over;

    assign busy   = (state_reg != M_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign sat    = sat_reg;

    always_comb begin
        a_half = cnt_reg[1] ? ua_reg[FLUX_W-1:HALF_W] : ua_reg[HALF_W-1:0];
        b_half = cnt_reg[0] ? ub_reg[FLUX_W-1:HALF_W] : ub_reg[HALF_W-1:0];
        pp     = FLUX_W'(a_half) * FLUX_W'(b_half);
        case (cnt_reg)
            2'd0:    pp_pos = PROD_W'(pp);
            2'd3:    pp_pos = PROD_W'(pp) << FLUX_W;
            default: pp_pos = PROD_W'(pp) << HALF_W;
        endcase
        rsh      = sh_reg[SHIFT_W-2:0];
        lsh      = (SHIFT_W-1)'(-sh_reg);
        lost_pos = (SHIFT_W+1)'(PROD_W) - (SHIFT_W+1)'(lsh);
        rem      = |(acc_reg & ((PROD_W'(1) << rsh) - PROD_W'(1)));
        mag2     = mag_reg + PROD_W'(inc_reg);
        lim      = neg_reg ? {1'b1, (FLUX_W-1)'(0)} : {1'b0, {(FLUX_W-1){1'b1}}};
        over     = lost_reg || (mag2[PROD_W-1:FLUX_W] != '0) || (mag2[FLUX_W-1:0] > lim);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE:  if (start) state_next = M_PP;
            M_PP:    if (cnt_reg == 2'd3) state_next = M_SHIFT;
            M_SHIFT: state_next = M_SAT;
            M_SAT:   state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == M_SAT);
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            M_IDLE: begin
                neg_reg <= a[FLUX_W-1] ^ b[FLUX_W-1];
                ua_reg  <= a[FLUX_W-1] ? FLUX_W'(-a) : a;
                ub_reg  <= b[FLUX_W-1] ? FLUX_W'(-b) : b;
                sh_reg  <= shift;
                acc_reg <= '0;
                cnt_reg <= '0;
            end
            M_PP: begin
                acc_reg <= acc_reg + pp_pos;
                cnt_reg <= cnt_reg + 1'b1;
            end
            M_SHIFT: begin
                if (!sh_reg[SHIFT_W-1]) begin
                    mag_reg  <= acc_reg >> rsh;
                    inc_reg  <= neg_reg && rem;
                    lost_reg <= 1'b0;
                end else begin
                    mag_reg  <= acc_reg << lsh;
                    inc_reg  <= 1'b0;
                    lost_reg <= |(acc_reg >> lost_pos);
                end
            end
            M_SAT: begin
                sat_reg <= over;
                if (over) begin
                    result_reg <= neg_reg ? {1'b1, (FLUX_W-1)'(0)} : {1'b0, {(FLUX_W-1){1'b1}}};
                end else begin
                    result_reg <= neg_reg ? FLUX_W'(-mag2[FLUX_W-1:0]) : mag2[FLUX_W-1:0];
                end
            end
            default: begin
                cnt_reg <= '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/ecff_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ecff_back import ecff_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  pop_valid,
    input  wire face_t pop_face,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output flux_t      out_data
);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_VN    = 3'd1;
    localparam logic [2:0] B_ISSUE = 3'd2;
    localparam logic [2:0] B_WAIT  = 3'd3;
    localparam logic [2:0] B_HOLD  = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic [STEP_W-1:0]          step_reg;
    logic [1:0]                 vn_cnt_reg;
    logic signed [VN_ACC_W-1:0] vn_acc_reg;
    logic signed [VN_W-1:0]     vn_reg;
    face_t                      face_reg;
    logic signed [FLUX_W-1:0]   rv_reg, t_reg, ke_reg, e_reg;
    logic signed [FLUX_W-1:0]   mass_reg, mx_reg, my_reg, mz_reg, en_reg;
    logic                       ovf_reg;
    flux_t                      out_reg;
    logic                       out_valid_reg;

    ucode_t                     uc;
    logic signed [STATE_W-1:0]  vel_sel;
    logic signed [NORMAL_W-1:0] nrm_sel;
    logic signed [VN_PROD_W-1:0] vn_prod;
    logic signed [VN_ACC_W-1:0] vn_sum;
    logic signed [FLUX_W-1:0]   op_a, op_b, dst_old, sum, wval;
    logic                       add_ovf;
    logic                       mul_start, mul_busy, mul_done, mul_sat;
    logic signed [FLUX_W-1:0]   mul_result;
    logic                       load_out;

    assign uc        = ucode(step_reg);
    assign pop       = (state_reg == B_IDLE) && pop_valid;
    assign mul_start = (state_reg == B_ISSUE);
    assign load_out  = (state_reg == B_HOLD) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // normal velocity, one component a cycle
    always_comb begin
        case (vn_cnt_reg)
            2'd0:    begin vel_sel = face_reg.velocity_x; nrm_sel = face_reg.normal_x; end
            2'd1:    begin vel_sel = face_reg.velocity_y; nrm_sel = face_reg.normal_y; end
            default: begin vel_sel = face_reg.velocity_z; nrm_sel = face_reg.normal_z; end
        endcase
        vn_prod = VN_PROD_W'(vel_sel) * VN_PROD_W'(nrm_sel);
        vn_sum  = vn_acc_reg + VN_ACC_W'(vn_prod);
    end

    always_comb begin
        case (uc.src_a)
            REG_RHO:   op_a = FLUX_W'(face_reg.density);
            REG_U:     op_a = FLUX_W'(face_reg.velocity_x);
            REG_V:     op_a = FLUX_W'(face_reg.velocity_y);
            REG_W_VEL: op_a = FLUX_W'(face_reg.velocity_z);
            REG_P:     op_a = FLUX_W'(face_reg.pressure);
            REG_RV:    op_a = rv_reg;
            REG_T:     op_a = t_reg;
            REG_E:     op_a = e_reg;
            default:   op_a = '0;
        endcase
    end

    always_comb begin
        case (uc.src_b)
            REG_U:     op_b = FLUX_W'(face_reg.velocity_x);
            REG_V:     op_b = FLUX_W'(face_reg.velocity_y);
            REG_W_VEL: op_b = FLUX_W'(face_reg.velocity_z);
            REG_NX:    op_b = FLUX_W'(face_reg.normal_x);
            REG_NY:    op_b = FLUX_W'(face_reg.normal_y);
            REG_NZ:    op_b = FLUX_W'(face_reg.normal_z);
            REG_AREA:  op_b = {{(FLUX_W-AREA_W){1'b0}}, face_reg.face_area};
            REG_VN:    op_b = FLUX_W'(vn_reg);
            REG_SEVEN: op_b = FLUX_W'(7);
            REG_KE:    op_b = ke_reg;
            default:   op_b = '0;
        endcase
    end

    always_comb begin
        case (uc.dst)
            REG_T:   dst_old = t_reg;
            REG_KE:  dst_old = ke_reg;
            REG_E:   dst_old = e_reg;
            default: dst_old = '0;
        endcase
        sum     = dst_old + mul_result;
        add_ovf = (dst_old[FLUX_W-1] == mul_result[FLUX_W-1]) &&
                  (sum[FLUX_W-1] != dst_old[FLUX_W-1]);
        if (!uc.accum) begin
            wval = mul_result;
        end else if (add_ovf) begin
            wval = dst_old[FLUX_W-1] ? {1'b1, (FLUX_W-1)'(0)} : {1'b0, {(FLUX_W-1){1'b1}}};
        end else begin
            wval = sum;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (pop_valid) state_next = B_VN;
            B_VN:    if (vn_cnt_reg == 2'd2) state_next = B_ISSUE;
            B_ISSUE: state_next = B_WAIT;
            B_WAIT: begin
                if (mul_done) begin
                    state_next = (step_reg == STEP_W'(UCODE_STEPS - 1)) ? B_HOLD : B_ISSUE;
                end
            end
            B_HOLD:  if (load_out) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == B_IDLE) begin
                step_reg <= '0;
            end else if (state_reg == B_WAIT && mul_done &&
                         step_reg != STEP_W'(UCODE_STEPS - 1)) begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            face_reg   <= pop_face;
            vn_acc_reg <= '0;
            vn_cnt_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        if (state_reg == B_VN) begin
            vn_acc_reg <= vn_sum;
            vn_cnt_reg <= vn_cnt_reg + 1'b1;
            vn_reg     <= vn_sum[VN_ACC_W-1:NORMAL_FRAC_BITS];
        end
        if (state_reg == B_WAIT && mul_done) begin
            ovf_reg <= ovf_reg || mul_sat || (uc.accum && add_ovf);
            case (uc.dst)
                REG_RV:   rv_reg   <= wval;
                REG_T:    t_reg    <= wval;
                REG_KE:   ke_reg   <= wval;
                REG_E:    e_reg    <= wval;
                REG_MASS: mass_reg <= wval;
                REG_MX:   mx_reg   <= wval;
                REG_MY:   my_reg   <= wval;
                REG_MZ:   mz_reg   <= wval;
                REG_EN:   en_reg   <= wval;
                default:  rv_reg   <= rv_reg;
            endcase
        end
        if (load_out) begin
            out_reg.mass     <= mass_reg;
            out_reg.mom_x    <= mx_reg;
            out_reg.mom_y    <= my_reg;
            out_reg.mom_z    <= mz_reg;
            out_reg.energy   <= en_reg;
            out_reg.last     <= face_reg.last;
            out_reg.overflow <= ovf_reg;
        end
    end

    ecff_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (op_a),
        .b       (op_b),
        .shift   (shift_amount(uc.shift)),
        .busy    (mul_busy),
        .done    (mul_done),
        .result  (mul_result),
        .sat     (mul_sat)
    );

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_busy)
        else $error("multiplier started while busy");

    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == B_WAIT)
        else $error("multiplier result with no step waiting");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> out_valid_reg)
        else $error("finished face not presented");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg < STEP_W'(UCODE_STEPS))
        else $error("step counter out of range");

endmodule

`default_nettype wire

FILE: hdl/euler_central_face_flux_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Central-scheme inviscid 3D Euler face flux. A left beat (s_op = 0) loads the held
// cell state and gives no result; a right beat (s_op = 1) is averaged
// with the held state on acceptance and queued (two faces deep), so the input takes
// one beat a cycle while the queue has room. The back end then takes each face in
// turn: the normal velocity from its three components, then eighteen exact
// 64x64 fixed-point products on one shared 32x32 multiplier, each step waiting for
// that multiplier to finish. The finished face sits in an output register while the
// next face is already being worked on.

module euler_central_face_flux_core import ecff_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_op,
    input  wire logic signed [STATE_W-1:0]  s_density,
    input  wire logic signed [STATE_W-1:0]  s_velocity_x,
    input  wire logic signed [STATE_W-1:0]  s_velocity_y,
    input  wire logic signed [STATE_W-1:0]  s_velocity_z,
    input  wire logic signed [STATE_W-1:0]  s_pressure,
    input  wire logic signed [NORMAL_W-1:0] s_normal_x,
    input  wire logic signed [NORMAL_W-1:0] s_normal_y,
    input  wire logic signed [NORMAL_W-1:0] s_normal_z,
    input  wire logic [AREA_W-1:0]          s_face_area,
    input  wire logic                       s_final_face,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [FLUX_W-1:0]        m_mass_flux,
    output logic signed [FLUX_W-1:0]        m_momentum_x_flux,
    output logic signed [FLUX_W-1:0]        m_momentum_y_flux,
    output logic signed [FLUX_W-1:0]        m_momentum_z_flux,
    output logic signed [FLUX_W-1:0]        m_energy_flux,
    output logic                            m_last_result,
    output logic                            m_overflow
);

    logic  fifo_full, push, pop, pop_valid;
    face_t push_face, pop_face;
    flux_t out_data;

    ecff_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_density    (s_density),
        .s_velocity_x (s_velocity_x),
        .s_velocity_y (s_velocity_y),
        .s_velocity_z (s_velocity_z),
        .s_pressure   (s_pressure),
        .s_normal_x   (s_normal_x),
        .s_normal_y   (s_normal_y),
        .s_normal_z   (s_normal_z),
        .s_face_area  (s_face_area),
        .s_final_face (s_final_face),
        .fifo_full    (fifo_full),
        .push         (push),
        .push_face    (push_face)
    );

    ecff_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_face (push_face),
        .full      (fifo_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_face  (pop_face)
    );

    ecff_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_face  (pop_face),
        .pop       (pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_mass_flux       = out_data.mass;
    assign m_momentum_x_flux = out_data.mom_x;
    assign m_momentum_y_flux = out_data.mom_y;
    assign m_momentum_z_flux = out_data.mom_z;
    assign m_energy_flux     = out_data.energy;
    assign m_last_result     = out_data.last;
    assign m_overflow        = out_data.overflow;

endmodule

`default_nettype wire

FILE: bench/ecff_flux_checker.sv
`timescale 1ns / 1ps

module ecff_flux_checker import ecff_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    input  wire logic  s_ready,
    input  wire logic  s_op,
    input  wire face_t s_beat,
    input  wire logic  m_valid,
    input  wire logic  m_ready,
    input  wire flux_t m_beat,
    output int         errors,
    output int         pending,
    output int         faces_checked,
    output int         saturated_faces
);

    localparam longint FLUX_MAX = 64'sh7fffffffffffffff;
    localparam longint FLUX_MIN = 64'sh8000000000000000;

    flux_t  expected_fluxes[$];
    longint held_rho, held_u, held_v, held_w, held_p;
    bit     clamp_seen;

    function automatic longint scaled_mul(input longint a, input longint b, input int sh);
        logic signed [139:0] wa, wb, pr, top_l, bot_l;
        wa = a;
        wb = b;
        top_l = FLUX_MAX;
        bot_l = FLUX_MIN;
        pr = wa * wb;
        if (sh >= 0) begin
            pr = pr >>> sh;
        end else begin
            pr = pr <<< (-sh);
        end
        if (pr > top_l) begin
            clamp_seen = 1'b1;
            return FLUX_MAX;
        end
        if (pr < bot_l) begin
            clamp_seen = 1'b1;
            return FLUX_MIN;
        end
        return longint'(pr[63:0]);
    endfunction

    function automatic longint clamped_sum(input longint a, input longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            clamp_seen = 1'b1;
            return s[64] ? FLUX_MIN : FLUX_MAX;
        end
        return longint'(s[63:0]);
    endfunction

    function automatic flux_t face_flux(input face_t f);
        longint rho, p, area, vn, rv, ke, e, t;
        longint vel[3], nrm[3], mom[3];
        flux_t  r;
        clamp_seen = 1'b0;
        rho    = (held_rho + longint'(f.density)) >>> 1;
        vel[0] = (held_u + longint'(f.velocity_x)) >>> 1;
        vel[1] = (held_v + longint'(f.velocity_y)) >>> 1;
        vel[2] = (held_w + longint'(f.velocity_z)) >>> 1;
        p      = (held_p + longint'(f.pressure)) >>> 1;
        nrm[0] = f.normal_x;
        nrm[1] = f.normal_y;
        nrm[2] = f.normal_z;
        area   = longint'({1'b0, f.face_area});
        vn = (vel[0] * nrm[0] + vel[1] * nrm[1] + vel[2] * nrm[2]) >>> NORMAL_FRAC_BITS;
        rv = scaled_mul(rho, vn, 2 * STATE_FRAC_BITS - OUT_FRAC_BITS);
        r.mass = scaled_mul(rv, area, STATE_FRAC_BITS);
        for (int i = 0; i < 3; i++) begin
            t = clamped_sum(scaled_mul(rv, vel[i], STATE_FRAC_BITS),
                            scaled_mul(p, nrm[i],
                                       STATE_FRAC_BITS + NORMAL_FRAC_BITS - OUT_FRAC_BITS));
            mom[i] = scaled_mul(t, area, STATE_FRAC_BITS);
        end
        r.mom_x = mom[0];
        r.mom_y = mom[1];
        r.mom_z = mom[2];
        ke = scaled_mul(vel[0], vel[0], 2 * STATE_FRAC_BITS - OUT_FRAC_BITS);
        ke = clamped_sum(ke, scaled_mul(vel[1], vel[1], 2 * STATE_FRAC_BITS - OUT_FRAC_BITS));
        ke = clamped_sum(ke, scaled_mul(vel[2], vel[2], 2 * STATE_FRAC_BITS - OUT_FRAC_BITS));
        e = clamped_sum(scaled_mul(p, 7, STATE_FRAC_BITS + 1 - OUT_FRAC_BITS),
                        scaled_mul(rho, ke, STATE_FRAC_BITS + 1));
        t = scaled_mul(e, vn, STATE_FRAC_BITS);
        r.energy   = scaled_mul(t, area, STATE_FRAC_BITS);
        r.last     = f.last;
        r.overflow = clamp_seen;
        return r;
    endfunction

    function automatic int field_bad(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    assign pending = expected_fluxes.size();

    initial begin
        errors = 0;
        faces_checked = 0;
        saturated_faces = 0;
        held_rho = 0;
        held_u = 0;
        held_v = 0;
        held_w = 0;
        held_p = 0;
    end

    always @(posedge aclk) begin
        flux_t want;
        int    bad;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (!s_op) begin
                    held_rho = s_beat.density;
                    held_u   = s_beat.velocity_x;
                    held_v   = s_beat.velocity_y;
                    held_w   = s_beat.velocity_z;
                    held_p   = s_beat.pressure;
                end else begin
                    expected_fluxes.push_back(face_flux(s_beat));
                end
            end
            if (m_valid && m_ready) begin
                if (expected_fluxes.size() == 0) begin
                    $display("%0t: unexpected result beat, mass actual %0d",
                             $time, m_beat.mass);
                    errors++;
                end else begin
                    want = expected_fluxes.pop_front();
                    bad = field_bad("mass_flux", want.mass, m_beat.mass)
                        + field_bad("momentum_x_flux", want.mom_x, m_beat.mom_x)
                        + field_bad("momentum_y_flux", want.mom_y, m_beat.mom_y)
                        + field_bad("momentum_z_flux", want.mom_z, m_beat.mom_z)
                        + field_bad("energy_flux", want.energy, m_beat.energy)
                        + field_bad("last_result", want.last, m_beat.last)
                        + field_bad("overflow", want.overflow, m_beat.overflow);
                    errors += bad;
                    faces_checked++;
                    if (want.overflow) begin
                        saturated_faces++;
                    end
                end
            end
        end
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import ecff_pkg::*;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    logic  s_op;
    face_t s_beat;
    logic  m_valid;
    logic  m_ready;
    flux_t m_beat;
    logic signed [FLUX_W-1:0] m_mass, m_mx, m_my, m_mz, m_en;
    logic  m_last, m_ovf;

    int errors, pending, faces_checked, saturated_faces;
    int beats_sent, results_taken;
    bit send_burst, recv_burst, long_hold_done;

    assign m_beat = {m_mass, m_mx, m_my, m_mz, m_en, m_last, m_ovf};

    euler_central_face_flux_core i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_density         (s_beat.density),
        .s_velocity_x      (s_beat.velocity_x),
        .s_velocity_y      (s_beat.velocity_y),
        .s_velocity_z      (s_beat.velocity_z),
        .s_pressure        (s_beat.pressure),
        .s_normal_x        (s_beat.normal_x),
        .s_normal_y        (s_beat.normal_y),
        .s_normal_z        (s_beat.normal_z),
        .s_face_area       (s_beat.face_area),
        .s_final_face      (s_beat.last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_mass_flux       (m_mass),
        .m_momentum_x_flux (m_mx),
        .m_momentum_y_flux (m_my),
        .m_momentum_z_flux (m_mz),
        .m_energy_flux     (m_en),
        .m_last_result     (m_last),
        .m_overflow        (m_ovf)
    );

    ecff_flux_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_beat          (s_beat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_beat          (m_beat),
        .errors          (errors),
        .pending         (pending),
        .faces_checked   (faces_checked),
        .saturated_faces (saturated_faces)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] pick_state();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 32'(int'($urandom_range(0, 65535)) - 32768);
            4, 5, 6:    return 32'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
            7, 8:       return $urandom;
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7fffffff;
                    1:       return 32'h80000000;
                    2:       return 32'hffffffff;
                    default: return 32'h0;
                endcase
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_normal();
        case ($urandom_range(0, 9))
            8: return 16'($urandom);
            9: begin
                case ($urandom_range(0, 4))
                    0:       return 16'sd16384;
                    1:       return -16'sd16384;
                    2:       return 16'h8000;
                    3:       return 16'h7fff;
                    default: return 16'h0;
                endcase
            end
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic face_t random_face();
        face_t f;
        f.density    = pick_state();
        f.velocity_x = pick_state();
        f.velocity_y = pick_state();
        f.velocity_z = pick_state();
        f.pressure   = pick_state();
        f.normal_x   = pick_normal();
        f.normal_y   = pick_normal();
        f.normal_z   = pick_normal();
        case ($urandom_range(0, 9))
            8:       f.face_area = 31'($urandom);
            9:       f.face_area = '1;
            default: f.face_area = 31'($urandom_range(0, 1 << 16));
        endcase
        f.last = 1'($urandom_range(0, 1));
        return f;
    endfunction

    function automatic face_t uniform_face(input logic [31:0] s, input logic [15:0] n,
                                           input logic [30:0] a, input logic fin);
        return '{s, s, s, s, s, n, n, n, a, fin};
    endfunction

    task automatic send_beat(input logic op, input face_t f);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            send_burst = ~send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_op    <= op;
        s_beat  <= f;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic send_face(input face_t left_f, input face_t right_f);
        send_beat(1'b0, left_f);
        send_beat(1'b1, right_f);
    endtask

    initial begin
        #8_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side
    initial begin
        int gap;
        m_ready = 1'b0;
        results_taken = 0;
        recv_burst = 0;
        long_hold_done = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!long_hold_done && results_taken >= 40) begin
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
                long_hold_done = 1;
            end else begin
                if ($urandom_range(0, 29) == 0) begin
                    recv_burst = ~recv_burst;
                end
                gap = recv_burst ? 0 : $urandom_range(0, 19);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_taken++;
        end
    end

    initial begin
        face_t f, g;
        int    pick;
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = 1'b0;
        s_beat = '0;
        beats_sent = 0;
        send_burst = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: right with nothing held, extremes, odd normals, repeated right
        send_beat(1'b1, random_face());
        send_face(uniform_face(32'h7fffffff, 16'sd16384, '1, 1'b0),
                  uniform_face(32'h7fffffff, 16'sd16384, '1, 1'b1));
        send_face(uniform_face(32'h80000000, 16'h8000, '1, 1'b1),
                  uniform_face(32'h80000000, 16'h8000, '1, 1'b0));
        send_face(uniform_face(32'h0, 16'h7fff, '1, 1'b1),
                  uniform_face(32'h0, 16'h0, '0, 1'b0));
        send_face(uniform_face(32'hffffffff, 16'hffff, 31'd4096, 1'b0),
                  uniform_face(32'hffffffff, 16'h7fff, 31'd4096, 1'b1));
        f = uniform_face(32'h0000_1000, 16'sd16384, 31'd4096, 1'b0);
        f.pressure = 32'h0001_0000;
        g = f;
        g.normal_y = -16'sd16384;
        g.normal_x = 16'h0;
        g.last = 1'b1;
        send_face(f, f);
        send_beat(1'b1, g);
        send_beat(1'b1, uniform_face(32'h0000_2000, -16'sd16384, 31'd1, 1'b0));
        send_face(uniform_face(32'h0100_0000, 16'sd9459, 31'h0010_0000, 1'b0),
                  uniform_face(32'hff00_0000, -16'sd9459, 31'h0010_0000, 1'b1));

        // random faces, mostly well-formed pairs
        while (beats_sent < 1400) begin
            if (beats_sent >= 700 && beats_sent < 703) begin
                s_valid <= 1'b0;
                while (pending != 0) @(posedge aclk);
                @(posedge aclk);
            end
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                send_face(random_face(), random_face());
            end else if (pick == 7) begin
                send_beat(1'b0, random_face());
            end else begin
                send_beat(1'b1, random_face());
            end
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        $display("%0d input beats driven, %0d faces checked, %0d of them saturated",
                 beats_sent, faces_checked, saturated_faces);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
